[hw/rtl/sia_pkg.sv]
// Shared types and codes for the slab item allocator.
// No dependencies; imported by sia_seq and slab_item_allocator_top.
`timescale 1ns / 1ps

package sia_pkg;

    // default geometry
    localparam int DEF_BLOCKS = 64;
    localparam int DEF_ITEMS  = 512;

    // item fields
    localparam int FUNC_W   = 2;
    localparam int FBLK_W   = 6;
    localparam int FSLOT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 2;
    localparam int MB_W     = 7;
    localparam int ME_W     = 7;
    localparam int IPB_W    = 10;

    // func codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADHDL  = 2'd2;

    // block classes
    localparam logic [1:0] CL_FULL    = 2'd0;
    localparam logic [1:0] CL_PARTIAL = 2'd1;
    localparam logic [1:0] CL_EMPTY   = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EMPTY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IPB        = 2'd2;

    localparam logic [MB_W-1:0]  RST_MAX_BLOCKS = 7'd64;
    localparam logic [ME_W-1:0]  RST_MAX_EMPTY  = 7'd0;
    localparam logic [IPB_W-1:0] RST_IPB        = 10'd512;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FBLK_W-1:0]  free_block;
        logic [FSLOT_W-1:0] free_slot;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FBLK_W-1:0]   got_block;
        logic [FSLOT_W-1:0]  got_slot;
        logic [COUNT_W-1:0]  live_blocks;
        logic [COUNT_W-1:0]  empty_blocks;
    } rsp_item_t;

    // config as the sequencer sees it (already clamped)
    typedef struct packed {
        logic [MB_W-1:0]  max_blocks;
        logic [ME_W-1:0]  max_empty;
        logic [IPB_W-1:0] items_per_block;
    } cfg_t;

    // sequencer handshake toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

[hw/rtl/sia_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sia_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/sia_seq.sv]
// Allocator sequencer: block table, list links, slot links and in-use rows in RAMs.
// Depends on sia_pkg and sia_ram.
`timescale 1ns / 1ps

module sia_seq
    import sia_pkg::*;
#(
    parameter int BLOCKS = DEF_BLOCKS,
    parameter int ITEMS  = DEF_ITEMS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  req_item_t req,
    input  cfg_t      cfg,
    input  logic      out_free,
    output seq_stat_t stat,
    output rsp_item_t res
);

    localparam int BW  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int BNW = $clog2(BLOCKS + 1);
    localparam int SW  = (ITEMS > 1) ? $clog2(ITEMS) : 1;
    localparam int CW  = $clog2(ITEMS + 1);
    localparam int LD  = BLOCKS * ITEMS;
    localparam int LW  = (LD > 1) ? $clog2(LD) : 1;
    localparam logic [BNW-1:0] BNONE = BNW'(BLOCKS);
    localparam logic [CW-1:0]  SNONE = CW'(ITEMS);

    typedef struct packed {
        logic [1:0]    cls;
        logic [CW-1:0] fc;
        logic [CW-1:0] bump;
        logic [CW-1:0] rh;
    } rec_t;

    localparam int RW = $bits(rec_t);

    typedef enum logic [2:0] {
        S_IDLE, S_ARD, S_ALNK, S_FCHK, S_CMT, S_INIT, S_DONE
    } state_t;

    state_t             st_reg;
    logic [BW-1:0]      b_reg;
    logic [SW-1:0]      s_reg;
    logic               fresh_reg;
    logic               recyc_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [BW-1:0]      gb_reg;
    logic [SW-1:0]      gs_reg;
    logic [BNW-1:0]     ph_reg, eh_reg, live_reg, ec_reg;
    logic [BLOCKS-1:0]  valid_reg, rowok_reg;
    logic [1:0]         cidx_reg;
    logic [BNW-1:0]     i_reg, n_reg;

    // pending writes, played out over the commit cycles
    logic               blk_we_reg, use_we_reg, lnk_we_reg;
    rec_t               blk_wd_reg;
    logic [ITEMS-1:0]   use_wd_reg;
    logic [LW-1:0]      lnk_wa_reg;
    logic [CW-1:0]      lnk_wd_reg;
    logic               pw_en_reg [3];
    logic [BW-1:0]      pw_a_reg  [3];
    logic [BNW-1:0]     pw_d_reg  [3];
    logic               nw_en_reg [3];
    logic [BW-1:0]      nw_a_reg  [3];
    logic [BNW-1:0]     nw_d_reg  [3];

    // RAM ports
    logic             rd_en, lnk_re;
    logic [BW-1:0]    rd_addr;
    logic [LW-1:0]    lnk_raddr;
    logic [RW-1:0]    blk_rd_raw;
    rec_t             blk_rd;
    logic [BNW-1:0]   nxt_rd, prv_rd;
    logic [ITEMS-1:0] use_rd;
    logic [CW-1:0]    lnk_rd;
    logic             blk_we, prv_we, nxt_we, use_we, lnk_we;
    logic [BW-1:0]    blk_wa, prv_wa, nxt_wa;
    rec_t             blk_wd;
    logic [BNW-1:0]   prv_wd, nxt_wd;

    assign blk_rd = rec_t'(blk_rd_raw);

    // ---------------------------------------------------------------
    // selection at accept time
    logic          ff_found;
    logic [BW-1:0] ff_idx;
    always_comb
    begin
        ff_found = 1'b0;
        ff_idx   = '0;
        for (int k = BLOCKS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                ff_found = 1'b1;
                ff_idx   = BW'(k);
            end
        end
    end

    logic          a_exh, a_fresh, f_range_ok;
    logic [BW-1:0] a_b;
    always_comb
    begin
        a_exh   = 1'b0;
        a_fresh = 1'b0;
        a_b     = ff_idx;
        if (ph_reg != BNONE)
        begin
            a_b = BW'(ph_reg);
        end
        else if (eh_reg != BNONE)
        begin
            a_b = BW'(eh_reg);
        end
        else if (32'(live_reg) >= 32'(cfg.max_blocks) || !ff_found)
        begin
            a_exh = 1'b1;
        end
        else
        begin
            a_fresh = 1'b1;
        end
    end

    assign f_range_ok = (32'(req.free_block) < BLOCKS) && (32'(req.free_slot) < ITEMS)
                        && valid_reg[BW'(req.free_block)];

    assign rd_en   = (st_reg == S_IDLE) && start;
    assign rd_addr = (req.func == FUNC_FREE) ? BW'(req.free_block) : a_b;

    // ---------------------------------------------------------------
    // common values
    rec_t             new_rec;
    logic [ITEMS-1:0] row_cur;
    logic [ITEMS-1:0] s_bit;

    assign new_rec = '{cls: CL_FULL, fc: CW'(cfg.items_per_block), bump: '0, rh: SNONE};
    assign row_cur = rowok_reg[b_reg] ? use_rd : '0;
    assign s_bit   = ITEMS'(1) << s_reg;

    // A_RD: pick recycled or bump slot
    rec_t ard_rec;
    logic ard_recyc;
    assign ard_rec   = fresh_reg ? new_rec : blk_rd;
    assign ard_recyc = (ard_rec.rh < SNONE);
    assign lnk_re    = (st_reg == S_ARD) && ard_recyc;
    assign lnk_raddr = LW'(LW'(b_reg) * LW'(ITEMS) + LW'(ard_rec.rh[SW-1:0]));

    // A_LNK: allocation update
    rec_t             a_rec;
    logic [BNW-1:0]   a_ph, a_eh, a_ec;
    logic [ITEMS-1:0] a_row;
    logic             a_pw_en [3];
    logic [BW-1:0]    a_pw_a  [3];
    logic [BNW-1:0]   a_pw_d  [3];
    logic             a_nw_en;
    logic [BW-1:0]    a_nw_a;
    logic [BNW-1:0]   a_nw_d;
    always_comb
    begin : alloc_calc
        rec_t          r;
        logic [1:0]    cls;
        logic [CW-1:0] fc;
        r = fresh_reg ? new_rec : blk_rd;
        a_ph = ph_reg;
        a_eh = eh_reg;
        a_ec = ec_reg;
        for (int k = 0; k < 3; k++)
        begin
            a_pw_en[k] = 1'b0;
            a_pw_a[k]  = '0;
            a_pw_d[k]  = BNONE;
        end
        a_nw_en = 1'b0;
        a_nw_a  = b_reg;
        a_nw_d  = ph_reg;
        cls = r.cls;
        // taking the empty head
        if (!fresh_reg && cls == CL_EMPTY)
        begin
            a_eh = nxt_rd;
            if (nxt_rd != BNONE)
            begin
                a_pw_en[0] = 1'b1;
                a_pw_a[0]  = BW'(nxt_rd);
            end
            if (ec_reg != '0)
            begin
                a_ec = ec_reg - 1'b1;
            end
            cls = CL_FULL;
        end
        fc = (r.fc != '0) ? r.fc - 1'b1 : '0;
        if (fc == '0)
        begin
            if (cls == CL_PARTIAL)
            begin
                a_ph = nxt_rd;
                if (nxt_rd != BNONE)
                begin
                    a_pw_en[1] = 1'b1;
                    a_pw_a[1]  = BW'(nxt_rd);
                end
            end
            cls = CL_FULL;
        end
        else if (cls != CL_PARTIAL)
        begin
            a_pw_en[2] = 1'b1;
            a_pw_a[2]  = b_reg;
            a_nw_en    = 1'b1;
            if (ph_reg != BNONE)
            begin
                a_pw_en[1] = 1'b1;
                a_pw_a[1]  = BW'(ph_reg);
                a_pw_d[1]  = BNW'(b_reg);
            end
            a_ph = BNW'(b_reg);
            cls  = CL_PARTIAL;
        end
        a_rec.cls  = cls;
        a_rec.fc   = fc;
        a_rec.bump = recyc_reg ? r.bump : r.bump + 1'b1;
        a_rec.rh   = recyc_reg ? lnk_rd : r.rh;
        a_row      = row_cur | s_bit;
    end

    // F_CHK: free update
    rec_t             f_rec;
    logic             f_bad, f_whole, f_kill;
    logic [BNW-1:0]   f_ph, f_eh, f_ec, f_live;
    logic             f_pw_en [3];
    logic [BW-1:0]    f_pw_a  [3];
    logic [BNW-1:0]   f_pw_d  [3];
    logic             f_nw_en [2];
    logic [BW-1:0]    f_nw_a  [2];
    logic [BNW-1:0]   f_nw_d  [2];
    always_comb
    begin : free_calc
        rec_t          r;
        logic [CW-1:0] fc;
        r = blk_rd;
        f_ph = ph_reg;
        f_eh = eh_reg;
        f_ec = ec_reg;
        f_live = live_reg;
        f_kill = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            f_pw_en[k] = 1'b0;
            f_pw_a[k]  = '0;
            f_pw_d[k]  = BNONE;
        end
        for (int k = 0; k < 2; k++)
        begin
            f_nw_en[k] = 1'b0;
            f_nw_a[k]  = '0;
            f_nw_d[k]  = BNONE;
        end
        f_bad = !row_cur[s_reg];
        fc = (r.fc < SNONE) ? r.fc + 1'b1 : r.fc;
        f_rec = '{cls: r.cls, fc: fc, bump: r.bump, rh: CW'(s_reg)};
        f_whole = (32'(fc) >= 32'(cfg.items_per_block));
        if (f_whole)
        begin
            // unlink from its list wherever it sits
            if (r.cls == CL_PARTIAL || r.cls == CL_EMPTY)
            begin
                if (prv_rd != BNONE)
                begin
                    f_nw_en[0] = 1'b1;
                    f_nw_a[0]  = BW'(prv_rd);
                    f_nw_d[0]  = nxt_rd;
                end
                else if (r.cls == CL_PARTIAL)
                begin
                    f_ph = nxt_rd;
                end
                else
                begin
                    f_eh = nxt_rd;
                end
                if (nxt_rd != BNONE)
                begin
                    f_pw_en[0] = 1'b1;
                    f_pw_a[0]  = BW'(nxt_rd);
                    f_pw_d[0]  = prv_rd;
                end
            end
            if (32'(ec_reg) >= 32'(cfg.max_empty))
            begin
                f_kill = 1'b1;
                if (live_reg != '0)
                begin
                    f_live = live_reg - 1'b1;
                end
            end
            else
            begin
                f_rec      = new_rec;
                f_rec.cls  = CL_EMPTY;
                f_pw_en[1] = 1'b1;
                f_pw_a[1]  = b_reg;
                f_nw_en[1] = 1'b1;
                f_nw_a[1]  = b_reg;
                f_nw_d[1]  = f_eh;
                if (f_eh != BNONE)
                begin
                    f_pw_en[2] = 1'b1;
                    f_pw_a[2]  = BW'(f_eh);
                    f_pw_d[2]  = BNW'(b_reg);
                end
                f_eh = BNW'(b_reg);
                f_ec = ec_reg + 1'b1;
            end
        end
        else if (r.cls == CL_FULL)
        begin
            f_rec.cls  = CL_PARTIAL;
            f_pw_en[1] = 1'b1;
            f_pw_a[1]  = b_reg;
            f_nw_en[1] = 1'b1;
            f_nw_a[1]  = b_reg;
            f_nw_d[1]  = ph_reg;
            if (ph_reg != BNONE)
            begin
                f_pw_en[2] = 1'b1;
                f_pw_a[2]  = BW'(ph_reg);
                f_pw_d[2]  = BNW'(b_reg);
            end
            f_ph = BNW'(b_reg);
        end
    end

    // ---------------------------------------------------------------
    // write ports: commit replay or init sweep
    logic init_wr, cmt0;
    rec_t init_rec;
    assign init_wr  = (st_reg == S_INIT) && (i_reg < n_reg);
    assign cmt0     = (st_reg == S_CMT) && (cidx_reg == 2'd0);
    assign init_rec = '{cls: CL_EMPTY, fc: CW'(cfg.items_per_block), bump: '0, rh: SNONE};

    always_comb
    begin
        if (st_reg == S_INIT)
        begin
            blk_we = init_wr;
            blk_wa = BW'(i_reg);
            blk_wd = init_rec;
            prv_we = init_wr;
            prv_wa = BW'(i_reg);
            prv_wd = (i_reg == '0) ? BNONE : i_reg - 1'b1;
            nxt_we = init_wr;
            nxt_wa = BW'(i_reg);
            nxt_wd = (i_reg + 1'b1 == n_reg) ? BNONE : i_reg + 1'b1;
        end
        else
        begin
            blk_we = cmt0 && blk_we_reg;
            blk_wa = b_reg;
            blk_wd = blk_wd_reg;
            prv_we = (st_reg == S_CMT) && pw_en_reg[cidx_reg];
            prv_wa = pw_a_reg[cidx_reg];
            prv_wd = pw_d_reg[cidx_reg];
            nxt_we = (st_reg == S_CMT) && nw_en_reg[cidx_reg];
            nxt_wa = nw_a_reg[cidx_reg];
            nxt_wd = nw_d_reg[cidx_reg];
        end
    end

    assign use_we = cmt0 && use_we_reg;
    assign lnk_we = cmt0 && lnk_we_reg;

    sia_ram #(.DEPTH(BLOCKS), .WIDTH(RW)) u_blk (
        .clk(clk), .we(blk_we), .waddr(blk_wa), .wdata(RW'(blk_wd)),
        .re(rd_en), .raddr(rd_addr), .rdata(blk_rd_raw)
    );

    sia_ram #(.DEPTH(BLOCKS), .WIDTH(BNW)) u_nxt (
        .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .re(rd_en), .raddr(rd_addr), .rdata(nxt_rd)
    );

    sia_ram #(.DEPTH(BLOCKS), .WIDTH(BNW)) u_prv (
        .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
        .re(rd_en), .raddr(rd_addr), .rdata(prv_rd)
    );

    sia_ram #(.DEPTH(BLOCKS), .WIDTH(ITEMS)) u_use (
        .clk(clk), .we(use_we), .waddr(b_reg), .wdata(use_wd_reg),
        .re(rd_en), .raddr(rd_addr), .rdata(use_rd)
    );

    sia_ram #(.DEPTH(LD), .WIDTH(CW)) u_lnk (
        .clk(clk), .we(lnk_we), .waddr(lnk_wa_reg), .wdata(lnk_wd_reg),
        .re(lnk_re), .raddr(lnk_raddr), .rdata(lnk_rd)
    );

    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            ph_reg     <= BNONE;
            eh_reg     <= BNONE;
            live_reg   <= '0;
            ec_reg     <= '0;
            valid_reg  <= '0;
            rowok_reg  <= '0;
            cidx_reg   <= '0;
            i_reg      <= '0;
            n_reg      <= '0;
            blk_we_reg <= 1'b0;
            use_we_reg <= 1'b0;
            lnk_we_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                pw_en_reg[k] <= 1'b0;
                nw_en_reg[k] <= 1'b0;
            end
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        status_reg <= ST_OK;
                        gb_reg     <= '0;
                        gs_reg     <= '0;
                        cidx_reg   <= '0;
                        case (req.func)
                            FUNC_ALLOC:
                            begin
                                b_reg     <= a_b;
                                fresh_reg <= a_fresh;
                                if (a_exh)
                                begin
                                    status_reg <= ST_EXHAUST;
                                    st_reg     <= S_DONE;
                                end
                                else
                                begin
                                    st_reg <= S_ARD;
                                end
                            end
                            FUNC_FREE:
                            begin
                                b_reg <= BW'(req.free_block);
                                s_reg <= SW'(req.free_slot);
                                if (f_range_ok)
                                begin
                                    st_reg <= S_FCHK;
                                end
                                else
                                begin
                                    status_reg <= ST_BADHDL;
                                    st_reg     <= S_DONE;
                                end
                            end
                            FUNC_INIT:
                            begin
                                valid_reg <= '0;
                                rowok_reg <= '0;
                                ph_reg    <= BNONE;
                                i_reg     <= '0;
                                n_reg     <= BNW'(cfg.max_empty);
                                st_reg    <= S_INIT;
                            end
                            default:
                            begin
                                st_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ARD:
                begin
                    recyc_reg <= ard_recyc;
                    s_reg     <= ard_recyc ? ard_rec.rh[SW-1:0] : ard_rec.bump[SW-1:0];
                    if (!ard_recyc && ard_rec.bump >= SNONE)
                    begin
                        status_reg <= ST_EXHAUST;
                        st_reg     <= S_DONE;
                    end
                    else
                    begin
                        st_reg <= S_ALNK;
                    end
                end
                S_ALNK:
                begin
                    ph_reg     <= a_ph;
                    eh_reg     <= a_eh;
                    ec_reg     <= a_ec;
                    blk_we_reg <= 1'b1;
                    blk_wd_reg <= a_rec;
                    use_we_reg <= 1'b1;
                    use_wd_reg <= a_row;
                    lnk_we_reg <= 1'b0;
                    rowok_reg[b_reg] <= 1'b1;
                    if (fresh_reg)
                    begin
                        valid_reg[b_reg] <= 1'b1;
                        live_reg         <= live_reg + 1'b1;
                    end
                    for (int k = 0; k < 3; k++)
                    begin
                        pw_en_reg[k] <= a_pw_en[k];
                        pw_a_reg[k]  <= a_pw_a[k];
                        pw_d_reg[k]  <= a_pw_d[k];
                    end
                    nw_en_reg[0] <= a_nw_en;
                    nw_a_reg[0]  <= a_nw_a;
                    nw_d_reg[0]  <= a_nw_d;
                    nw_en_reg[1] <= 1'b0;
                    nw_en_reg[2] <= 1'b0;
                    gb_reg <= b_reg;
                    gs_reg <= s_reg;
                    st_reg <= S_CMT;
                end
                S_FCHK:
                begin
                    if (f_bad)
                    begin
                        status_reg <= ST_BADHDL;
                        st_reg     <= S_DONE;
                    end
                    else
                    begin
                        ph_reg     <= f_ph;
                        eh_reg     <= f_eh;
                        ec_reg     <= f_ec;
                        live_reg   <= f_live;
                        blk_we_reg <= !f_kill;
                        blk_wd_reg <= f_rec;
                        use_we_reg <= !f_whole;
                        use_wd_reg <= row_cur & ~s_bit;
                        lnk_we_reg <= 1'b1;
                        lnk_wa_reg <= LW'(LW'(b_reg) * LW'(ITEMS) + LW'(s_reg));
                        lnk_wd_reg <= blk_rd.rh;
                        if (f_whole)
                        begin
                            rowok_reg[b_reg] <= 1'b0;
                        end
                        if (f_kill)
                        begin
                            valid_reg[b_reg] <= 1'b0;
                        end
                        for (int k = 0; k < 3; k++)
                        begin
                            pw_en_reg[k] <= f_pw_en[k];
                            pw_a_reg[k]  <= f_pw_a[k];
                            pw_d_reg[k]  <= f_pw_d[k];
                        end
                        for (int k = 0; k < 2; k++)
                        begin
                            nw_en_reg[k] <= f_nw_en[k];
                            nw_a_reg[k]  <= f_nw_a[k];
                            nw_d_reg[k]  <= f_nw_d[k];
                        end
                        nw_en_reg[2] <= 1'b0;
                        st_reg <= S_CMT;
                    end
                end
                S_CMT:
                begin
                    if (cidx_reg == 2'd2)
                    begin
                        st_reg <= S_DONE;
                    end
                    cidx_reg <= cidx_reg + 1'b1;
                end
                S_INIT:
                begin
                    if (init_wr)
                    begin
                        valid_reg[BW'(i_reg)] <= 1'b1;
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        eh_reg   <= (n_reg != '0) ? '0 : BNONE;
                        live_reg <= n_reg;
                        ec_reg   <= n_reg;
                        st_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.idle = (st_reg == S_IDLE);
    assign stat.done = (st_reg == S_DONE) && out_free;

    assign res.status       = status_reg;
    assign res.got_block    = FBLK_W'(gb_reg);
    assign res.got_slot     = FSLOT_W'(gs_reg);
    assign res.live_blocks  = COUNT_W'(live_reg);
    assign res.empty_blocks = COUNT_W'(ec_reg);

endmodule

[hw/rtl/slab_item_allocator_top.sv]
// Slab item allocator, top level: config registers, request/response channels.
// Depends on sia_pkg and sia_seq (which holds the RAMs).
`timescale 1ns / 1ps

// Usage
//   req channel   : one item per request (allocate, free handle, init pool,
//                   or no-op). Accepted when req_valid is high and req_stall
//                   is low. req_stall is high while an item is in work.
//   rsp channel   : exactly one item per request, in order. Taken when
//                   rsp_valid is high and rsp_stall is low.
//   cfg channel   : register writes (max_blocks, max_empty, items_per_block),
//                   always ready; write only while the block is idle.
// Flow: each alloc or free reads the block RAMs at accept (a recycled alloc
//   also reads the link RAM), then replays its list-link writes in commit
//   steps, at most one write per RAM per step. An item is taken only while
//   the sequencer is idle, so a new request waits until the last one is
//   through. The next request is taken in the cycle after the response is
//   loaded, even while that response is still stalled.
// Reset: all blocks invalid, both lists empty, counts zero, registers at
//   64 / 0 / 512. In-use rows are cleared by per-block row-ok bits, so no
//   clearing pass is needed.
// Stall: a finished response waits in the output register; the sequencer
//   holds its result until the register frees up.

module slab_item_allocator_top
    import sia_pkg::*;
#(
    parameter int BLOCKS = DEF_BLOCKS,
    parameter int ITEMS  = DEF_ITEMS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_item_t            req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_item_t            rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IPB_W-1:0]     cfg_data
);

    // raw config registers
    logic [MB_W-1:0]  max_blocks_reg;
    logic [ME_W-1:0]  max_empty_reg;
    logic [IPB_W-1:0] ipb_reg;

    // clamped config seen by the sequencer
    cfg_t      cfg_eff;
    logic [MB_W-1:0] mb_eff;

    seq_stat_t stat;
    rsp_item_t seq_res;
    logic      start, out_free;
    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_blocks_reg <= RST_MAX_BLOCKS;
            max_empty_reg  <= RST_MAX_EMPTY;
            ipb_reg        <= RST_IPB;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_BLOCKS: max_blocks_reg <= cfg_data[MB_W-1:0];
                CFG_MAX_EMPTY:  max_empty_reg  <= cfg_data[ME_W-1:0];
                CFG_IPB:        ipb_reg        <= cfg_data;
                default:        ;
            endcase
        end
    end

    // max_blocks above BLOCKS acts as BLOCKS; max_empty limited to that;
    // items_per_block of 0 acts as 1, above ITEMS as ITEMS
    assign mb_eff = (32'(max_blocks_reg) > BLOCKS) ? MB_W'(BLOCKS) : max_blocks_reg;
    assign cfg_eff.max_blocks = mb_eff;
    assign cfg_eff.max_empty  = (max_empty_reg > mb_eff) ? mb_eff : max_empty_reg;
    assign cfg_eff.items_per_block = (ipb_reg == '0) ? IPB_W'(1) :
                                     (32'(ipb_reg) > ITEMS) ? IPB_W'(ITEMS) : ipb_reg;

    assign req_stall = !stat.idle;
    assign start     = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    sia_seq #(.BLOCKS(BLOCKS), .ITEMS(ITEMS)) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .cfg      (cfg_eff),
        .out_free (out_free),
        .stat     (stat),
        .res      (seq_res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            rsp_reg <= seq_res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
